@@ sv/e2ep5_pkg.sv @@
// ----------------------------------------------------------------------------
// E2E profile 5 check package
// Shared types, constants and CRC/status helper functions for the
// receive-side end-to-end profile 5 check.
// ----------------------------------------------------------------------------
package e2ep5_pkg;

    localparam int MAX_BYTES_DEF = 4096;

    localparam int COUNT_W  = 13;
    localparam int OFFSET_W = 12;
    localparam int CRC_W    = 16;
    localparam int CNT_W    = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0]   CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]   CRC_POLY  = 16'h1021;
    localparam logic [CNT_W-1:0]   CNT_MAX   = 8'hFF;
    localparam logic [COUNT_W-1:0] COUNT_SAT = 13'd8191;

    localparam logic [CRC_W-1:0]   DATA_ID_RST   = 16'd0;
    localparam logic [OFFSET_W-1:0] OFFSET_RST   = 12'd0;
    localparam logic [COUNT_W-1:0] LENGTH_RST    = 13'd3;
    localparam logic [CNT_W-1:0]   MAX_DELTA_RST = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DATA_ID     = 2'd0,
        REG_CRC_OFFSET  = 2'd1,
        REG_DATA_LENGTH = 2'd2,
        REG_MAX_DELTA   = 2'd3
    } e2ep5_reg_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_OKSOMELOST    = 3'd1,
        ST_ERROR         = 3'd2,
        ST_REPEATED      = 3'd3,
        ST_NONEWDATA     = 3'd4,
        ST_WRONGSEQUENCE = 3'd5
    } e2ep5_status_t;

    typedef enum logic [2:0] {
        MAP_OK            = 3'd0,
        MAP_ERROR         = 3'd1,
        MAP_REPEATED      = 3'd2,
        MAP_NONEWDATA     = 3'd3,
        MAP_WRONGSEQUENCE = 3'd4
    } e2ep5_map_t;

    typedef enum logic {
        RC_OK         = 1'b0,
        RC_WRONG_LEN  = 1'b1
    } e2ep5_rc_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       last_byte;
    } e2ep5_in_t;

    typedef struct packed {
        e2ep5_rc_t          return_code;
        e2ep5_status_t      check_status;
        e2ep5_map_t         mapped_status;
        logic [CNT_W-1:0]   received_counter;
        logic [CNT_W-1:0]   counter_delta;
    } e2ep5_out_t;

    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0] crc_in,
        input logic [7:0]       b
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[CRC_W-1])
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic e2ep5_map_t map_status(
        input e2ep5_rc_t     rc,
        input e2ep5_status_t st
    );
        e2ep5_map_t m;
        if (rc != RC_OK)
        begin
            m = MAP_ERROR;
        end
        else
        begin
            case (st)
                ST_OK, ST_OKSOMELOST: m = MAP_OK;
                ST_REPEATED:          m = MAP_REPEATED;
                ST_NONEWDATA:         m = MAP_NONEWDATA;
                ST_WRONGSEQUENCE:     m = MAP_WRONGSEQUENCE;
                default:              m = MAP_ERROR;
            endcase
        end
        return m;
    endfunction

endpackage

@@ sv/e2e_profile5_check_core.sv @@
// Timing: the last byte or no-new-data item is held in the input register,
// and its result is written from there to the result register.
// Throughput: one item per cycle unless the result stalls; the byte-wide CRC
// update and data-id tail fold run in the single compute stage between them.
// Reset: asynchronous, active low; configuration and message state return to
// their defaults and both pipeline stages come up empty.
// ----------------------------------------------------------------------------
// E2E profile 5 check core
// Byte-serial receive-side check: CRC-16 over the message and data id,
// length check and counter sequence classification.
// ----------------------------------------------------------------------------
module e2e_profile5_check_core
    import e2ep5_pkg::*;
#(
    parameter int MAX_BYTES = MAX_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  e2ep5_in_t            item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output e2ep5_out_t           result
);

    localparam logic [COUNT_W-1:0] MaxBytesC = COUNT_W'(MAX_BYTES);

    logic [CRC_W-1:0]    data_id_reg;
    logic [OFFSET_W-1:0] crc_offset_reg;
    logic [COUNT_W-1:0]  data_length_reg;
    logic [CNT_W-1:0]    max_delta_reg;

    logic                hold_valid_reg;
    e2ep5_in_t           hold_item_reg;

    logic [CRC_W-1:0]    running_crc_reg, running_crc_next;
    logic [COUNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [CRC_W-1:0]    captured_crc_reg, captured_crc_next;
    logic [CNT_W-1:0]    captured_counter_reg, captured_counter_next;
    logic [CNT_W-1:0]    last_counter_reg, last_counter_next;
    e2ep5_status_t       last_status_reg, last_status_next;

    logic                result_valid_reg, result_valid_next;
    e2ep5_out_t          result_reg, result_next;

    logic                produces;
    logic                advance;
    logic [COUNT_W-1:0]  off0, off1, off2;
    logic [CRC_W-1:0]    crc_upd;
    logic [CRC_W-1:0]    crc_lo;
    logic [CRC_W-1:0]    crc_final;
    logic [CRC_W-1:0]    cap_crc_upd;
    logic [CNT_W-1:0]    cap_cnt_upd;
    logic [CRC_W-1:0]    crc_run_upd;
    logic [COUNT_W-1:0]  count_inc;
    logic [CNT_W-1:0]    delta;
    e2ep5_rc_t           rc;
    e2ep5_status_t       seq_status;

    assign produces   = hold_item_reg.kind | hold_item_reg.last_byte;
    assign advance    = hold_valid_reg & (~produces | ~result_valid_reg | result_ready);
    assign item_ready = ~hold_valid_reg | advance;

    assign off0 = {1'b0, crc_offset_reg};
    assign off1 = off0 + COUNT_W'(1);
    assign off2 = off0 + COUNT_W'(2);

    always_comb
    begin
        cap_crc_upd = captured_crc_reg;
        cap_cnt_upd = captured_counter_reg;
        crc_run_upd = running_crc_reg;
        crc_upd     = crc_byte(running_crc_reg, hold_item_reg.data_byte);
        priority if (byte_count_reg == off0)
        begin
            cap_crc_upd = {captured_crc_reg[CRC_W-1:8], hold_item_reg.data_byte};
        end
        else if (byte_count_reg == off1)
        begin
            cap_crc_upd = {hold_item_reg.data_byte, captured_crc_reg[7:0]};
        end
        else
        begin
            if (byte_count_reg == off2)
            begin
                cap_cnt_upd = hold_item_reg.data_byte;
            end
            crc_run_upd = crc_upd;
        end
    end

    assign count_inc = (byte_count_reg == COUNT_SAT) ? byte_count_reg
                                                     : byte_count_reg + COUNT_W'(1);
    assign delta     = cap_cnt_upd - last_counter_reg;
    assign rc        = ((count_inc == data_length_reg) && (count_inc <= MaxBytesC))
                       ? RC_OK : RC_WRONG_LEN;
    assign crc_lo    = crc_byte(crc_run_upd, data_id_reg[7:0]);
    assign crc_final = crc_byte(crc_lo, data_id_reg[15:8]);

    always_comb
    begin
        priority if (delta > max_delta_reg)
        begin
            seq_status = ST_WRONGSEQUENCE;
        end
        else if (delta == '0)
        begin
            seq_status = ST_REPEATED;
        end
        else if (delta == CNT_W'(1))
        begin
            seq_status = ST_OK;
        end
        else
        begin
            seq_status = ST_OKSOMELOST;
        end
    end

    always_comb
    begin
        running_crc_next      = running_crc_reg;
        byte_count_next       = byte_count_reg;
        captured_crc_next     = captured_crc_reg;
        captured_counter_next = captured_counter_reg;
        last_counter_next     = last_counter_reg;
        last_status_next      = last_status_reg;
        result_next           = result_reg;
        result_valid_next     = result_valid_reg & ~result_ready;

        if (advance)
        begin
            if (hold_item_reg.kind)
            begin
                running_crc_next             = CRC_INIT;
                byte_count_next              = '0;
                captured_crc_next            = '0;
                captured_counter_next        = '0;
                last_status_next             = ST_NONEWDATA;
                result_valid_next            = 1'b1;
                result_next.return_code      = RC_OK;
                result_next.check_status     = ST_NONEWDATA;
                result_next.mapped_status    = map_status(RC_OK, ST_NONEWDATA);
                result_next.received_counter = '0;
                result_next.counter_delta    = '0;
            end
            else if (hold_item_reg.last_byte)
            begin
                if (rc == RC_OK)
                begin
                    if (crc_final == cap_crc_upd)
                    begin
                        last_status_next  = seq_status;
                        last_counter_next = cap_cnt_upd;
                    end
                    else
                    begin
                        last_status_next = ST_ERROR;
                    end
                end
                running_crc_next             = CRC_INIT;
                byte_count_next              = '0;
                captured_crc_next            = '0;
                captured_counter_next        = '0;
                result_valid_next            = 1'b1;
                result_next.return_code      = rc;
                result_next.check_status     = last_status_next;
                result_next.mapped_status    = map_status(rc, last_status_next);
                result_next.received_counter = cap_cnt_upd;
                result_next.counter_delta    = delta;
            end
            else
            begin
                running_crc_next      = crc_run_upd;
                byte_count_next       = count_inc;
                captured_crc_next     = cap_crc_upd;
                captured_counter_next = cap_cnt_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_id_reg     <= DATA_ID_RST;
            crc_offset_reg  <= OFFSET_RST;
            data_length_reg <= LENGTH_RST;
            max_delta_reg   <= MAX_DELTA_RST;
        end
        else if (cfg_we)
        begin
            unique case (e2ep5_reg_t'(cfg_index))
                REG_DATA_ID:     data_id_reg     <= cfg_wdata;
                REG_CRC_OFFSET:  crc_offset_reg  <= cfg_wdata[OFFSET_W-1:0];
                REG_DATA_LENGTH: data_length_reg <= cfg_wdata[COUNT_W-1:0];
                REG_MAX_DELTA:   max_delta_reg   <= cfg_wdata[CNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg       <= 1'b0;
            result_valid_reg     <= 1'b0;
            running_crc_reg      <= CRC_INIT;
            byte_count_reg       <= '0;
            captured_crc_reg     <= '0;
            captured_counter_reg <= '0;
            last_counter_reg     <= CNT_MAX;
            last_status_reg      <= ST_ERROR;
        end
        else
        begin
            if (item_ready)
            begin
                hold_valid_reg <= item_valid;
            end
            result_valid_reg     <= result_valid_next;
            running_crc_reg      <= running_crc_next;
            byte_count_reg       <= byte_count_next;
            captured_crc_reg     <= captured_crc_next;
            captured_counter_reg <= captured_counter_next;
            last_counter_reg     <= last_counter_next;
            last_status_reg      <= last_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            hold_item_reg <= item;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ sv/e2ep5_checker.sv @@
// ----------------------------------------------------------------------------
// E2E profile 5 port checker
// Concurrent checks on the result channel of the profile 5 check core.
// ----------------------------------------------------------------------------
module e2ep5_checker
    import e2ep5_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_ready,
    input e2ep5_out_t           result
);

    // A stalled result must hold until its transfer completes.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_len_error_map: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.return_code == RC_WRONG_LEN
        |-> result.mapped_status == MAP_ERROR)
        else $error("length error not mapped to error");

    a_nonewdata: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.return_code == RC_OK
        && result.check_status == ST_NONEWDATA
        |-> result.received_counter == '0 && result.counter_delta == '0
        && result.mapped_status == MAP_NONEWDATA)
        else $error("no-new-data result fields wrong");

    a_seq_delta: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.return_code == RC_OK
        && (result.check_status == ST_OK || result.check_status == ST_REPEATED)
        |-> result.counter_delta == ((result.check_status == ST_OK) ? 8'd1 : 8'd0))
        else $error("sequence status does not match counter delta");

endmodule

bind e2e_profile5_check_core e2ep5_checker u_e2ep5_checker (.*);

@@ tb/e2e_profile5_check_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// E2E profile 5 check core testbench
// Streams protected messages, broken messages and no-new-data events into the
// check core under changing settings and random stalls on both channels, and
// compares every verdict with an in-bench prediction of the check.
// ----------------------------------------------------------------------------
module e2e_profile5_check_core_test;

    import e2ep5_pkg::*;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_we = 1'b0;
    e2ep5_reg_t      cfg_index = REG_DATA_ID;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic            item_valid = 1'b0;
    logic            item_ready;
    e2ep5_in_t       item = '0;
    logic            result_valid;
    logic            result_ready = 1'b0;
    e2ep5_out_t      result;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent_items = 0;
    int error_count = 0;

    // Settings as the core holds them.
    logic [15:0] cfg_data_id;
    logic [11:0] cfg_offset;
    logic [12:0] cfg_length;
    logic [7:0]  cfg_max_delta;

    // Message and sequence state of the check.
    logic [15:0]   msg_crc;
    logic [15:0]   msg_rx_crc;
    logic [12:0]   msg_count;
    logic [7:0]    msg_rx_counter;
    logic [7:0]    seq_last_counter;
    e2ep5_status_t seq_status;

    e2ep5_out_t expected_verdicts[$];
    logic [7:0] frame_bytes[$];

    e2e_profile5_check_core u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c;
        for (int k = 7; k >= 0; k--)
        begin
            if (r[15] ^ b[k])
            begin
                r = {r[14:0], 1'b0} ^ 16'h1021;
            end
            else
            begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

    function automatic e2ep5_map_t fold_status(input e2ep5_rc_t rc, input e2ep5_status_t st);
        e2ep5_map_t m;
        m = MAP_ERROR;
        if (rc == RC_OK)
        begin
            case (st)
                ST_OK:            m = MAP_OK;
                ST_OKSOMELOST:    m = MAP_OK;
                ST_REPEATED:      m = MAP_REPEATED;
                ST_NONEWDATA:     m = MAP_NONEWDATA;
                ST_WRONGSEQUENCE: m = MAP_WRONGSEQUENCE;
                default:          m = MAP_ERROR;
            endcase
        end
        return m;
    endfunction

    task automatic clear_frame_state();
        msg_crc = CRC_INIT;
        msg_rx_crc = '0;
        msg_count = '0;
        msg_rx_counter = '0;
    endtask

    task automatic reset_model();
        cfg_data_id = DATA_ID_RST;
        cfg_offset = OFFSET_RST;
        cfg_length = LENGTH_RST;
        cfg_max_delta = MAX_DELTA_RST;
        clear_frame_state();
        seq_last_counter = CNT_MAX;
        seq_status = ST_ERROR;
    endtask

    task automatic predict_verdict(input e2ep5_in_t it);
        e2ep5_out_t v;
        e2ep5_rc_t  rc;
        logic [15:0] crc;
        logic [7:0]  delta;
        int pos;
        if (it.kind)
        begin
            clear_frame_state();
            seq_status = ST_NONEWDATA;
            v.return_code = RC_OK;
            v.check_status = ST_NONEWDATA;
            v.mapped_status = MAP_NONEWDATA;
            v.received_counter = '0;
            v.counter_delta = '0;
            expected_verdicts.push_back(v);
        end
        else
        begin
            pos = msg_count;
            if (pos == cfg_offset)
            begin
                msg_rx_crc[7:0] = it.data_byte;
            end
            else if (pos == cfg_offset + 1)
            begin
                msg_rx_crc[15:8] = it.data_byte;
            end
            else
            begin
                if (pos == cfg_offset + 2)
                begin
                    msg_rx_counter = it.data_byte;
                end
                msg_crc = crc16_update(msg_crc, it.data_byte);
            end
            if (msg_count != COUNT_SAT)
            begin
                msg_count++;
            end
            if (it.last_byte)
            begin
                delta = msg_rx_counter - seq_last_counter;
                rc = (msg_count == cfg_length && msg_count <= MAX_BYTES_DEF) ? RC_OK
                                                                             : RC_WRONG_LEN;
                if (rc == RC_OK)
                begin
                    crc = crc16_update(crc16_update(msg_crc, cfg_data_id[7:0]),
                                       cfg_data_id[15:8]);
                    if (crc != msg_rx_crc)
                    begin
                        seq_status = ST_ERROR;
                    end
                    else
                    begin
                        if (delta > cfg_max_delta)
                        begin
                            seq_status = ST_WRONGSEQUENCE;
                        end
                        else if (delta == 8'd0)
                        begin
                            seq_status = ST_REPEATED;
                        end
                        else if (delta == 8'd1)
                        begin
                            seq_status = ST_OK;
                        end
                        else
                        begin
                            seq_status = ST_OKSOMELOST;
                        end
                        seq_last_counter = msg_rx_counter;
                    end
                end
                v.return_code = rc;
                v.check_status = seq_status;
                v.mapped_status = fold_status(rc, seq_status);
                v.received_counter = msg_rx_counter;
                v.counter_delta = delta;
                expected_verdicts.push_back(v);
                clear_frame_state();
            end
        end
    endtask

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        e2ep5_out_t want;
        if (result_valid && result_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, result);
                error_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (result.return_code !== want.return_code)
                begin
                    report_mismatch("return_code", 8'(want.return_code),
                                    8'(result.return_code));
                end
                if (result.check_status !== want.check_status)
                begin
                    report_mismatch("check_status", 8'(want.check_status),
                                    8'(result.check_status));
                end
                if (result.mapped_status !== want.mapped_status)
                begin
                    report_mismatch("mapped_status", 8'(want.mapped_status),
                                    8'(result.mapped_status));
                end
                if (result.received_counter !== want.received_counter)
                begin
                    report_mismatch("received_counter", want.received_counter,
                                    result.received_counter);
                end
                if (result.counter_delta !== want.counter_delta)
                begin
                    report_mismatch("counter_delta", want.counter_delta, result.counter_delta);
                end
            end
        end
    end

    task automatic send_item(input e2ep5_in_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        predict_verdict(it);
        sent_items++;
    endtask

    task automatic send_no_new_data();
        send_item({1'b1, 8'($urandom_range(255)), 1'($urandom_range(1))});
    endtask

    task automatic send_bytes(input int n, input bit mark_last);
        for (int i = 0; i < n; i++)
        begin
            send_item({1'b0, frame_bytes[i], 1'(mark_last && i == n - 1)});
        end
    endtask

    task automatic send_frame();
        send_bytes(frame_bytes.size(), 1'b1);
    endtask

    // Fills frame_bytes with a well-formed message for the current settings.
    task automatic build_frame(input logic [7:0] counter);
        logic [15:0] crc;
        frame_bytes.delete();
        for (int i = 0; i < cfg_length; i++)
        begin
            frame_bytes.push_back(8'($urandom_range(255)));
        end
        frame_bytes[cfg_offset + 2] = counter;
        crc = CRC_INIT;
        for (int i = 0; i < cfg_length; i++)
        begin
            if (i != cfg_offset && i != cfg_offset + 1)
            begin
                crc = crc16_update(crc, frame_bytes[i]);
            end
        end
        crc = crc16_update(crc16_update(crc, cfg_data_id[7:0]), cfg_data_id[15:8]);
        frame_bytes[cfg_offset] = crc[7:0];
        frame_bytes[cfg_offset + 1] = crc[15:8];
    endtask

    task automatic send_good_frame(input logic [7:0] delta);
        build_frame(seq_last_counter + delta);
        send_frame();
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input e2ep5_reg_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_DATA_ID:     cfg_data_id = val;
            REG_CRC_OFFSET:  cfg_offset = val[11:0];
            REG_DATA_LENGTH: cfg_length = val[12:0];
            REG_MAX_DELTA:   cfg_max_delta = val[7:0];
            default:         ;
        endcase
    endtask

    task automatic configure(input logic [15:0] id, input int off, input int len, input int md);
        wait_idle();
        write_reg(REG_DATA_ID, id);
        write_reg(REG_CRC_OFFSET, 16'(off));
        write_reg(REG_DATA_LENGTH, 16'(len));
        write_reg(REG_MAX_DELTA, 16'(md));
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_setting();
        send_good_frame(8'd1);
        send_good_frame(8'd0);
        send_no_new_data();
        send_good_frame(8'd1);
    endtask

    task automatic test_counter_classes();
        configure(16'hFFFF, 2, 5, 3);
        send_good_frame(8'd1);
        send_good_frame(8'd3);
        send_good_frame(8'd2);
        send_good_frame(8'd4);
        send_good_frame(8'd0);
        configure(16'h0000, 0, 3, 0);
        send_good_frame(8'd0);
        send_good_frame(8'd1);
        configure(16'hA5C3, 1, 4, 255);
        send_good_frame(8'd255);
        send_good_frame(8'd128);
    endtask

    task automatic test_crc_errors();
        configure(16'h1234, 1, 6, 2);
        build_frame(seq_last_counter + 8'd1);
        frame_bytes[cfg_offset] ^= 8'h01;
        send_frame();
        build_frame(seq_last_counter + 8'd1);
        frame_bytes[cfg_length - 1] ^= 8'h80;
        send_frame();
        send_good_frame(8'd1);
    endtask

    task automatic test_length_errors();
        configure(16'h5A5A, 5, 8, 1);
        build_frame(seq_last_counter + 8'd1);
        send_bytes(3, 1'b1);
        build_frame(seq_last_counter + 8'd1);
        send_bytes(6, 1'b1);
        build_frame(seq_last_counter + 8'd1);
        frame_bytes.push_back(8'hFF);
        send_frame();
        build_frame(seq_last_counter + 8'd1);
        send_bytes(4, 1'b0);
        send_no_new_data();
        send_good_frame(8'd1);
    endtask

    task automatic test_long_messages();
        configure(16'hFFFF, 45, 48, 255);
        send_good_frame(8'd7);
        configure(16'h0000, 0, 40, 1);
        send_good_frame(8'd1);
        configure(16'h8001, 0, 32, 1);
        frame_bytes.delete();
        repeat (60) frame_bytes.push_back(8'($urandom_range(255)));
        send_frame();
        send_good_frame(8'd1);
    endtask

    task automatic pick_random_setting();
        logic [15:0] id;
        int len;
        int off;
        int md;
        case ($urandom_range(3))
            0:       id = 16'h0000;
            1:       id = 16'hFFFF;
            default: id = 16'($urandom_range(65535));
        endcase
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 10);
        off = ($urandom_range(3) == 0) ? len - 3 : $urandom_range(0, len - 3);
        case ($urandom_range(4))
            0:       md = 0;
            1:       md = 255;
            2:       md = 1;
            default: md = $urandom_range(255);
        endcase
        configure(id, off, len, md);
    endtask

    task automatic send_random_frame();
        int r;
        int n;
        logic [7:0] delta;
        case ($urandom_range(5))
            0:       delta = 8'd0;
            1:       delta = 8'd1;
            2:       delta = 8'd2;
            3:       delta = cfg_max_delta;
            4:       delta = cfg_max_delta + 8'd1;
            default: delta = 8'($urandom_range(255));
        endcase
        build_frame(seq_last_counter + delta);
        n = frame_bytes.size();
        r = $urandom_range(99);
        if (r < 62)
        begin
            send_frame();
        end
        else if (r < 72)
        begin
            frame_bytes[$urandom_range(n - 1)] ^= 8'(1 << $urandom_range(7));
            send_frame();
        end
        else if (r < 78)
        begin
            send_bytes($urandom_range(1, n - 1), 1'b1);
        end
        else if (r < 84)
        begin
            repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(255)));
            send_frame();
        end
        else if (r < 90)
        begin
            send_bytes($urandom_range(0, n - 1), 1'b0);
            send_no_new_data();
        end
        else if (r < 95)
        begin
            send_no_new_data();
        end
        else
        begin
            frame_bytes.delete();
            repeat ($urandom_range(1, n + 2)) frame_bytes.push_back(8'($urandom_range(255)));
            send_frame();
        end
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_items);
        int first;
        int frames_left;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        first = sent_items;
        frames_left = 0;
        while (sent_items - first < n_items)
        begin
            if (frames_left == 0)
            begin
                pick_random_setting();
                frames_left = $urandom_range(6, 14);
            end
            send_random_frame();
            frames_left--;
        end
        wait_idle();
    endtask

    initial
    begin
        reset_model();
        send_idle_pct = 34;
        recv_idle_pct = 75;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_setting();
        test_counter_classes();
        test_crc_errors();
        test_length_errors();
        test_long_messages();
        test_random_traffic(34, 75, 155);
        test_random_traffic(75, 34, 155);
        test_random_traffic(0, 0, 155);
        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/e2ep5_pkg.sv
sv/e2e_profile5_check_core.sv
sv/e2ep5_checker.sv
tb/e2e_profile5_check_core_test.sv
